// ===== src/text_console_writer_defines.svh =====
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH

// same-cycle implication, checked on clk and masked during reset
`define TCW_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on clk and masked during reset
`define TCW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/tcw_pkg.sv =====
`timescale 1ns / 1ps

package tcw_pkg;

    localparam logic [1:0] CMD_PUT   = 2'd0;
    localparam logic [1:0] CMD_CLEAR = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam logic [7:0] NEWLINE_CODE = 8'h0A;
    localparam logic [7:0] SPACE_CODE   = 8'h20;
    localparam logic [7:0] RESET_COLOR  = 8'h0F;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] char_code;
        logic [4:0] read_row;
        logic [6:0] read_col;
    } tcw_in_t;

    typedef struct packed {
        logic [15:0] cell_value;
        logic [6:0]  cursor_col_out;
        logic [4:0]  cursor_row_out;
        logic        did_scroll;
    } tcw_out_t;

    typedef enum logic [2:0] {
        SW_HOLD,
        SW_INC,
        SW_ZERO,
        SW_COPY_START,
        SW_LAST_ROW
    } tcw_sweep_op_t;

    typedef struct packed {
        logic          accept;
        tcw_sweep_op_t sweep_op;
        logic          fill_wr;
        logic          reset_fill;
        logic          copy_rd;
        logic          load_out;
    } tcw_cmd_t;

    typedef struct packed {
        logic [1:0] in_command;
        logic       scroll_needed;
        logic       sweep_last;
        logic       copy_pending;
    } tcw_status_t;

endpackage

// ===== src/tcw_ctrl.sv =====
`timescale 1ns / 1ps
`include "text_console_writer_defines.svh"

module tcw_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  tcw_pkg::tcw_status_t status,
    output tcw_pkg::tcw_cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_COPY,
        S_BLANK,
        S_CLEAR,
        S_FIN
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        cmd            = '0;
        cmd.sweep_op   = tcw_pkg::SW_HOLD;
        state_next     = state_reg;
        unique case (state_reg)
            S_INIT:
            begin
                // power-up pass writes the default blank everywhere
                cmd.fill_wr    = 1'b1;
                cmd.reset_fill = 1'b1;
                if (status.sweep_last)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.sweep_op = tcw_pkg::SW_INC;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (status.in_command == tcw_pkg::CMD_PUT && status.scroll_needed)
                    begin
                        cmd.sweep_op = tcw_pkg::SW_COPY_START;
                        state_next   = S_COPY;
                    end
                    else if (status.in_command == tcw_pkg::CMD_CLEAR)
                    begin
                        cmd.sweep_op = tcw_pkg::SW_ZERO;
                        state_next   = S_CLEAR;
                    end
                    else
                    begin
                        state_next = S_FIN;
                    end
                end
            end
            S_COPY:
            begin
                cmd.copy_rd = 1'b1;
                if (status.sweep_last)
                begin
                    cmd.sweep_op = tcw_pkg::SW_LAST_ROW;
                    state_next   = S_BLANK;
                end
                else
                begin
                    cmd.sweep_op = tcw_pkg::SW_INC;
                end
            end
            S_BLANK:
            begin
                // on entry the last copied cell still owns the write port; blank fill waits for copy_pending to clear
                if (!status.copy_pending)
                begin
                    cmd.fill_wr = 1'b1;
                    if (status.sweep_last)
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        cmd.sweep_op = tcw_pkg::SW_INC;
                    end
                end
            end
            S_CLEAR:
            begin
                cmd.fill_wr = 1'b1;
                if (status.sweep_last)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.sweep_op = tcw_pkg::SW_INC;
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    `TCW_ASSERT_NOW(a_fill_no_copy_clash, cmd.fill_wr, !status.copy_pending,
        "blank write collides with pending copy write")
    `TCW_ASSERT_NEXT(a_load_sets_valid, cmd.load_out, out_valid_reg,
        "result loaded but out_valid not raised")
    `TCW_ASSERT_NOW(a_load_only_free, cmd.load_out && out_valid_reg, out_ready,
        "result overwritten before it was taken")

endmodule

// ===== src/tcw_datapath.sv =====
`timescale 1ns / 1ps
`include "text_console_writer_defines.svh"

module tcw_datapath #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tcw_pkg::tcw_in_t     in_item,
    input  logic                 cfg_valid,
    input  logic [7:0]           cfg_data,
    input  tcw_pkg::tcw_cmd_t    cmd,
    output tcw_pkg::tcw_status_t status,
    output tcw_pkg::tcw_out_t    out_item
);

    localparam int CELLS  = ROWS * COLUMNS;
    localparam int ADDR_W = $clog2(CELLS);

    localparam logic [ADDR_W-1:0] COL_STEP   = ADDR_W'(COLUMNS);
    localparam logic [ADDR_W-1:0] LAST_BASE  = ADDR_W'((ROWS - 1) * COLUMNS);
    localparam logic [ADDR_W-1:0] CELLS_LAST = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] SWEEP_STEP = ADDR_W'(1);
    localparam logic [4:0]        LAST_ROW   = 5'(ROWS - 1);
    localparam logic [6:0]        LAST_COL   = 7'(COLUMNS - 1);
    localparam logic [5:0]        ROWS_LIM   = 6'(ROWS);
    localparam logic [7:0]        COLS_LIM   = 8'(COLUMNS);

    logic [15:0] mem [CELLS];
    logic [15:0] rdata_reg;

    logic [6:0]        cursor_col_reg, cursor_col_next;
    logic [4:0]        cursor_row_reg, cursor_row_next;
    logic [ADDR_W-1:0] row_base_reg, row_base_next;
    logic [7:0]        color_reg, color_next;
    logic [ADDR_W-1:0] sweep_reg, sweep_next;
    logic              copy_pending_reg;
    logic [ADDR_W-1:0] copy_addr_reg;
    logic              scroll_res_reg, scroll_res_next;
    logic              read_hit_reg, read_hit_next;
    tcw_pkg::tcw_out_t out_item_reg;

    logic              is_newline;
    logic              advance_row;
    logic              scroll_needed;
    logic              put_wr;
    logic              read_in_range;
    logic [ADDR_W-1:0] read_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [15:0]       wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        fill_color;

    assign is_newline    = (in_item.char_code == tcw_pkg::NEWLINE_CODE);
    assign advance_row   = is_newline || (cursor_col_reg == LAST_COL);
    assign scroll_needed = advance_row && (cursor_row_reg == LAST_ROW);
    assign read_in_range = ({1'b0, in_item.read_row} < ROWS_LIM)
                        && ({1'b0, in_item.read_col} < COLS_LIM);
    assign read_addr     = ADDR_W'(in_item.read_row) * COL_STEP + ADDR_W'(in_item.read_col);
    assign put_wr        = cmd.accept && (in_item.command == tcw_pkg::CMD_PUT) && !is_newline;
    assign fill_color    = cmd.reset_fill ? tcw_pkg::RESET_COLOR : color_reg;

    always_comb
    begin
        cursor_col_next = cursor_col_reg;
        cursor_row_next = cursor_row_reg;
        row_base_next   = row_base_reg;
        scroll_res_next = scroll_res_reg;
        read_hit_next   = read_hit_reg;
        if (cmd.accept)
        begin
            scroll_res_next = 1'b0;
            read_hit_next   = 1'b0;
            case (in_item.command)
                tcw_pkg::CMD_PUT:
                begin
                    if (advance_row)
                    begin
                        cursor_col_next = '0;
                        if (scroll_needed)
                        begin
                            // cursor parks at the start of the bottom row
                            cursor_row_next = LAST_ROW;
                            row_base_next   = LAST_BASE;
                            scroll_res_next = 1'b1;
                        end
                        else
                        begin
                            cursor_row_next = cursor_row_reg + 5'd1;
                            row_base_next   = row_base_reg + COL_STEP;
                        end
                    end
                    else
                    begin
                        cursor_col_next = cursor_col_reg + 7'd1;
                    end
                end
                tcw_pkg::CMD_CLEAR:
                begin
                    cursor_col_next = '0;
                    cursor_row_next = '0;
                    row_base_next   = '0;
                end
                tcw_pkg::CMD_READ:
                begin
                    read_hit_next = read_in_range;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (cmd.sweep_op)
            tcw_pkg::SW_INC:        sweep_next = sweep_reg + SWEEP_STEP;
            tcw_pkg::SW_ZERO:       sweep_next = '0;
            tcw_pkg::SW_COPY_START: sweep_next = COL_STEP;
            tcw_pkg::SW_LAST_ROW:   sweep_next = LAST_BASE;
            default:                sweep_next = sweep_reg;
        endcase
    end

    always_comb
    begin
        color_next = color_reg;
        if (cfg_valid)
        begin
            color_next = cfg_data;
        end
    end

    // single write port: pending copy, blank fill or character put
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = sweep_reg;
        wr_data = {fill_color, tcw_pkg::SPACE_CODE};
        if (copy_pending_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = copy_addr_reg;
            wr_data = rdata_reg;
        end
        else if (cmd.fill_wr)
        begin
            wr_en = 1'b1;
        end
        else if (put_wr)
        begin
            wr_en   = 1'b1;
            wr_addr = row_base_reg + ADDR_W'(cursor_col_reg);
            wr_data = {color_reg, in_item.char_code};
        end
    end

    assign rd_en   = cmd.copy_rd || (cmd.accept && in_item.command == tcw_pkg::CMD_READ);
    assign rd_addr = cmd.copy_rd ? sweep_reg : read_addr;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        copy_addr_reg <= sweep_reg - COL_STEP;
        if (cmd.load_out)
        begin
            out_item_reg.cell_value     <= read_hit_reg ? rdata_reg : 16'h0000;
            out_item_reg.cursor_col_out <= cursor_col_reg;
            out_item_reg.cursor_row_out <= cursor_row_reg;
            out_item_reg.did_scroll     <= scroll_res_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_col_reg   <= '0;
            cursor_row_reg   <= '0;
            row_base_reg     <= '0;
            color_reg        <= tcw_pkg::RESET_COLOR;
            sweep_reg        <= '0;
            copy_pending_reg <= 1'b0;
            scroll_res_reg   <= 1'b0;
            read_hit_reg     <= 1'b0;
        end
        else
        begin
            cursor_col_reg   <= cursor_col_next;
            cursor_row_reg   <= cursor_row_next;
            row_base_reg     <= row_base_next;
            color_reg        <= color_next;
            sweep_reg        <= sweep_next;
            copy_pending_reg <= cmd.copy_rd;
            scroll_res_reg   <= scroll_res_next;
            read_hit_reg     <= read_hit_next;
        end
    end

    assign status.in_command    = in_item.command;
    assign status.scroll_needed = scroll_needed;
    assign status.sweep_last    = (sweep_reg == CELLS_LAST);
    assign status.copy_pending  = copy_pending_reg;
    assign out_item             = out_item_reg;

    `TCW_ASSERT_NOW(a_cursor_in_range, 1'b1,
        (cursor_row_reg <= LAST_ROW) && (cursor_col_reg <= LAST_COL),
        "cursor outside the screen")
    `TCW_ASSERT_NOW(a_row_base_matches, 1'b1,
        row_base_reg == ADDR_W'(ADDR_W'(cursor_row_reg) * COL_STEP),
        "row base address out of step with cursor row")

endmodule

// ===== src/text_console_writer.sv =====
`timescale 1ns / 1ps
// put, newline, read and unused commands: accepted in S_IDLE, then S_FIN loads the result; one item at a time
// scroll: a one-cell-per-cycle copy sweep of the store, then a blank sweep once the last copy is written
// clear: one blank cell written per cycle through the single write port
// reset: asynchronous active-low rst_n; afterwards a fill pass writes attribute 0x0F with space to
// every cell, no item is taken until it ends

module text_console_writer #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  tcw_pkg::tcw_in_t  in_item,
    output logic              out_valid,
    input  logic              out_ready,
    output tcw_pkg::tcw_out_t out_item,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [7:0]        cfg_data
);

    tcw_pkg::tcw_cmd_t    cmd;
    tcw_pkg::tcw_status_t status;

    assign cfg_ready = 1'b1;

    tcw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    tcw_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_item),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .out_item  (out_item)
    );

endmodule
